### rtl/rha_pkg.sv
// ----------------------------------------------------------------------------
// rha_pkg: shared definitions for the range histogram accumulator
// Holds the store size, field widths, operation and register codes, the
// controller states and the command bundle passed to the bin store.
// ----------------------------------------------------------------------------
package rha_pkg;

  // Store size and derived widths.
  localparam int MAX_BINS   = 256;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int NB_W       = $clog2(MAX_BINS + 1);
  localparam int CNT_W      = 32;
  localparam int SAMPLE_W   = 32;
  localparam int NUM_BINS_W = 9;
  localparam int SEL_W      = 8;
  localparam int IDX_W      = 8;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;

  // Operation codes carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_ACCUM = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_NUM_BINS   = 2'd2
  } reg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_RD,
    S_WR,
    S_OUT
  } state_t;

  // Command bundle for the bin store.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [BIN_W-1:0] addr;
    logic [CNT_W-1:0] wdata;
  } store_cmd_t;

endpackage

### rtl/rha_bin_div.sv
// ----------------------------------------------------------------------------
// rha_bin_div: sample to bin index mapper
// Compares the sample with the range edges, then scales the offset by the
// number of inner bins and divides by the span one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rha_bin_div
  import rha_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] range_low,
  input  logic [SAMPLE_W-1:0] range_high,
  input  logic [NB_W-1:0]     nb,
  output logic                done,
  output logic [BIN_W-1:0]    bin
);

  localparam int PROD_W = BIN_W + SAMPLE_W;
  localparam int STEP_W = $clog2(BIN_W + 1);

  logic [SAMPLE_W-1:0] off;
  logic [SAMPLE_W-1:0] span;
  logic [BIN_W-1:0]    scale;
  logic                mul_pend;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] rem;
  logic [BIN_W-1:0]    low;
  logic [BIN_W-1:0]    quo;

  logic                below;
  logic                above;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                ge;
  logic [BIN_W-1:0]    quo_next;

  // Range edge compares on the incoming sample.
  assign below = $signed(sample) < $signed(range_low);
  assign above = $signed(sample) >= $signed(range_high);

  // Scaled offset and one restoring division step.
  assign prod     = PROD_W'(scale) * PROD_W'(off);
  assign trial    = {rem, low[BIN_W-1]};
  assign diff     = trial - {1'b0, span};
  assign ge       = trial >= {1'b0, span};
  assign quo_next = {quo[BIN_W-2:0], ge};

  // Control: start, multiply cycle, then BIN_W division steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      step     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (below || above) begin
          done <= 1'b1;
        end else begin
          mul_pend <= 1'b1;
        end
      end else if (mul_pend) begin
        mul_pend <= 1'b0;
        step     <= STEP_W'(BIN_W);
      end else if (step != '0) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      off   <= sample - range_low;
      span  <= range_high - range_low;
      scale <= BIN_W'(nb - NB_W'(2));
      if (below) begin
        bin <= '0;
      end else if (above) begin
        bin <= BIN_W'(nb - NB_W'(1));
      end
    end else if (mul_pend) begin
      rem <= prod[PROD_W-1:BIN_W];
      low <= prod[BIN_W-1:0];
      quo <= '0;
    end else if (step != '0) begin
      rem <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      low <= {low[BIN_W-2:0], 1'b0};
      quo <= quo_next;
      if (step == STEP_W'(1)) begin
        bin <= quo_next + BIN_W'(1);
      end
    end
  end

endmodule

### rtl/rha_store.sv
// ----------------------------------------------------------------------------
// rha_store: bin counter memory
// One synchronous RAM of counters with a registered read. A valid bit per
// entry lets a clear empty every bin at once.
// ----------------------------------------------------------------------------
module rha_store
  import rha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  store_cmd_t       cmd,
  output logic [CNT_W-1:0] rd_count
);

  logic [CNT_W-1:0]    mem [MAX_BINS];
  logic [MAX_BINS-1:0] valid;
  logic [CNT_W-1:0]    mem_q;
  logic                rd_valid;

  // Counter RAM, write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[cmd.addr];
    end
  end

  // Entry valid bits: an entry never written since a clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid[cmd.addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= valid[cmd.addr];
      end
    end
  end

  assign rd_count = rd_valid ? mem_q : '0;

endmodule

### rtl/range_histogram_accumulator.sv
// ----------------------------------------------------------------------------
// range_histogram_accumulator: histogram with underflow and overflow bins
// Sequences accumulate, clear and read operations against the bin store.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one operation per beat: opcode in s_tuser, sample
// and bin_select in s_tdata. The m_ channel returns exactly one beat per
// operation with bin_index and bin_count. The cfg channel writes range_low,
// range_high and num_bins, which the user must write only while the block is
// idle; the block itself does not enforce it. cfg_ready is always high.
// One operation is in flight at a time. An accumulate maps its sample to a
// bin, by the bit-serial divider inside the range, then reads and writes it;
// a read only reads, and clear and unused opcodes go straight to output.
// The next beat is taken once the result sits in the output register, so a
// stalled receiver holds one result while the following operation runs up
// to its own result. Reset loads the register defaults and empties every
// bin at once, as a clear operation does; no clearing pass is needed.
// ----------------------------------------------------------------------------
module range_histogram_accumulator
  import rha_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // sample[31:0], bin_select[39:32]
  input  logic [OP_W-1:0]      s_tuser,   // opcode[1:0]
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // bin_index[7:0], bin_count[39:8]
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  state_t                state;
  state_t                state_next;
  logic [SAMPLE_W-1:0]   range_low;
  logic [SAMPLE_W-1:0]   range_high;
  logic [NUM_BINS_W-1:0] num_bins;
  logic [NB_W-1:0]       nb;

  logic [OP_W-1:0]       op;
  logic [SEL_W-1:0]      sel;
  logic [BIN_W-1:0]      addr;
  logic [IDX_W-1:0]      res_index;
  logic [CNT_W-1:0]      res_count;
  logic [IDX_W-1:0]      out_index;
  logic [CNT_W-1:0]      out_count;

  logic                  s_fire;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [BIN_W-1:0]      div_bin;
  logic [CNT_W-1:0]      rd_count;
  logic [CNT_W-1:0]      inc_count;
  store_cmd_t            cmd;

  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign div_start = s_fire && (s_tuser == OP_ACCUM);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= 32'd0;
      range_high <= 32'd65536;
      num_bins   <= NUM_BINS_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        REG_NUM_BINS:   num_bins   <= cfg_data[NUM_BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Bins in use, clamped to the supported range.
  always_comb begin
    if (32'(num_bins) < 32'd3) begin
      nb = NB_W'(3);
    end else if (32'(num_bins) > 32'(MAX_BINS)) begin
      nb = NB_W'(MAX_BINS);
    end else begin
      nb = NB_W'(num_bins);
    end
  end

  rha_bin_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .sample     (s_tdata[31:0]),
    .range_low  (range_low),
    .range_high (range_high),
    .nb         (nb),
    .done       (div_done),
    .bin        (div_bin)
  );

  rha_store u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_count (rd_count)
  );

  // Saturating increment of the counter just read.
  assign inc_count = (rd_count == '1) ? rd_count : rd_count + CNT_W'(1);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (s_tuser)
            OP_ACCUM: state_next = S_BIN;
            OP_READ:  state_next = S_RD;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_BIN: begin
        if (div_done) begin
          state_next = S_RD;
        end
      end
      S_RD:  state_next = S_WR;
      S_WR:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the controller: input ready and store commands.
  always_comb begin
    s_tready  = 1'b0;
    cmd.rd_en = 1'b0;
    cmd.wr_en = 1'b0;
    cmd.clr   = 1'b0;
    cmd.addr  = addr;
    cmd.wdata = inc_count;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.clr  = s_tvalid && (s_tuser == OP_CLEAR);
      end
      S_RD:    cmd.rd_en = 1'b1;
      S_WR:    cmd.wr_en = (op == OP_ACCUM);
      default: ;
    endcase
  end

  // Operation registers and result assembly.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          op        <= s_tuser;
          sel       <= s_tdata[39:32];
          addr      <= BIN_W'(s_tdata[39:32]);
          res_index <= (s_tuser == OP_READ) ? IDX_W'(s_tdata[39:32]) : '0;
          res_count <= '0;
        end
      end
      S_BIN: begin
        if (div_done) begin
          addr      <= div_bin;
          res_index <= IDX_W'(div_bin);
        end
      end
      S_WR: begin
        if (op == OP_ACCUM) begin
          res_count <= inc_count;
        end else if (32'(sel) < 32'(nb)) begin
          res_count <= rd_count;
        end else begin
          res_count <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_index <= res_index;
      out_count <= res_count;
    end
  end

  assign m_tdata = {out_count, out_index};

endmodule

### tb/sv/tb_range_histogram_accumulator.sv
// ----------------------------------------------------------------------------
// tb_range_histogram_accumulator: self-checking bench for the range histogram
// A local copy of the bin counters and range registers predicts every result
// beat. Stimulus starts with directed edge cases. Several range settings then
// follow, each with random accumulate, clear, read and spare-opcode beats.
// Both stream sides idle at random, and a long receiver hold fills the block.
// ----------------------------------------------------------------------------
module tb_range_histogram_accumulator;
  import rha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 205;
  localparam int NUM_PHASES    = 8;

  // The opcode left unused by the package.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // One operation beat and one result beat.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEL_W-1:0] sel;
    logic [31:0]      sample;
  } hist_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } bin_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;   // sample[31:0], bin_select[39:32]
  logic [OP_W-1:0]      s_tuser = '0;   // opcode[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;        // bin_index[7:0], bin_count[39:8]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Mirror of the block's registers and bins.
  logic [31:0]      range_lo_q = 32'd0;
  logic [31:0]      range_hi_q = 32'd65536;
  logic [8:0]       bins_reg_q = 9'd256;
  logic [CNT_W-1:0] bin_tally [MAX_BINS];

  hist_op_t    pending_ops[$];
  bin_result_t expected_bins[$];
  hist_op_t    in_flight;
  int          errors = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  range_histogram_accumulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bins actually in use once the register is clamped.
  function automatic int unsigned active_bins();
    int unsigned nb;
    nb = bins_reg_q;
    if (nb < 3) nb = 3;
    if (nb > MAX_BINS) nb = MAX_BINS;
    return nb;
  endfunction

  // Applies one operation to the mirrored bins and returns its result beat.
  function automatic bin_result_t apply_histogram_op(hist_op_t item);
    bin_result_t r;
    int unsigned nb;
    int unsigned b;
    longint      lo;
    longint      hi;
    longint      x;
    r  = '0;
    nb = active_bins();
    lo = $signed(range_lo_q);
    hi = $signed(range_hi_q);
    x  = $signed(item.sample);
    case (item.op)
      OP_ACCUM: begin
        if (x < lo) b = 0;
        else if (x >= hi) b = nb - 1;
        else b = 1 + int'(((longint'(nb) - 2) * (x - lo)) / (hi - lo));
        if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1;
        r.idx   = b[IDX_W-1:0];
        r.count = bin_tally[b];
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_BINS; i++) bin_tally[i] = '0;
      end
      OP_READ: begin
        r.idx = item.sel;
        if (item.sel < nb) r.count = bin_tally[item.sel];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random operation, with samples aimed mostly inside the current range.
  function automatic hist_op_t draw_op();
    hist_op_t    it;
    int unsigned pick;
    int unsigned nb;
    longint      lo;
    longint      hi;
    longint      x;
    nb        = active_bins();
    lo        = $signed(range_lo_q);
    hi        = $signed(range_hi_q);
    it.sample = $urandom;
    it.sel    = SEL_W'($urandom_range(255));
    pick      = $urandom_range(99);
    if (pick < 68) it.op = OP_ACCUM;
    else if (pick < 71) it.op = OP_CLEAR;
    else if (pick < 97) it.op = OP_READ;
    else it.op = OP_SPARE;

    if (it.op == OP_ACCUM) begin
      pick = $urandom_range(99);
      if (pick < 55 && hi > lo) begin
        x = lo + longint'({$urandom, $urandom} % (hi - lo));
        it.sample = x[31:0];
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0: x = lo;
          1: x = lo - 1;
          2: x = hi - 1;
          default: x = hi;
        endcase
        it.sample = x[31:0];
      end
    end else if (it.op == OP_READ && $urandom_range(99) < 75) begin
      it.sel = SEL_W'($urandom_range(nb - 1));
    end
    return it;
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [31:0] sample,
                          input logic [SEL_W-1:0] sel);
    hist_op_t it;
    it.op     = op;
    it.sample = sample;
    it.sel    = sel;
    pending_ops.push_back(it);
  endtask

  // Register write on the config channel; the mirror follows on the handshake.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RANGE_LOW:  range_lo_q = value;
      REG_RANGE_HIGH: range_hi_q = value;
      REG_NUM_BINS:   bins_reg_q = value[8:0];
      default: ;
    endcase
  endtask

  // Waits until every queued beat has gone in and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || s_tvalid || expected_bins.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: presents queued operations and predicts each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_bins.push_back(apply_histogram_op(in_flight));
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_flight = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= in_flight.op;
          s_tdata  <= {in_flight.sel, in_flight.sample};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random backpressure plus one long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_req) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      m_tready <= !hold_req && hold_left <= 1 && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: each beat against the oldest prediction.
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected result beat bin_index %0d bin_count %0d",
                 $time, m_tdata[7:0], m_tdata[39:8]);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        if (m_tdata[7:0] !== want.idx) begin
          $display("%0t: bin_index expected %0d actual %0d",
                   $time, want.idx, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[39:8] !== want.count) begin
          $display("%0t: bin_count of bin %0d expected %0d actual %0d",
                   $time, want.idx, want.count, m_tdata[39:8]);
          errors++;
        end
      end
    end
  end

  // Stimulus: directed cases at the reset settings, then one phase per setting.
  initial begin
    longint      lo_v;
    longint      hi_v;
    longint      tmp;
    logic [31:0] nb_word;
    int unsigned nb;
    for (int i = 0; i < MAX_BINS; i++) bin_tally[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset range is [0, 1.0) over 256 bins.
    queue_op(OP_READ,   32'h0000_0000, 8'd0);
    queue_op(OP_ACCUM,  32'h8000_0000, 8'd0);
    queue_op(OP_ACCUM,  32'h7FFF_FFFF, 8'hFF);
    queue_op(OP_ACCUM,  32'h0000_0000, 8'd0);
    queue_op(OP_ACCUM,  32'h0000_FFFF, 8'd0);
    queue_op(OP_ACCUM,  32'h0001_0000, 8'd0);
    queue_op(OP_ACCUM,  32'hFFFF_FFFF, 8'd0);
    queue_op(OP_ACCUM,  32'h0000_8000, 8'd0);
    queue_op(OP_READ,   32'hFFFF_FFFF, 8'd0);
    queue_op(OP_READ,   32'h0000_0000, 8'hFF);
    queue_op(OP_READ,   32'h5555_AAAA, 8'd128);
    queue_op(OP_SPARE,  32'hFFFF_FFFF, 8'hFF);
    queue_op(OP_CLEAR,  32'hFFFF_FFFF, 8'hFF);
    queue_op(OP_READ,   32'h0000_0000, 8'hFF);
    queue_op(OP_ACCUM,  32'h0000_0001, 8'd0);
    queue_op(OP_READ,   32'h0000_0000, 8'd1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Range settings, extremes first.
      case (p)
        0: begin lo_v = -64'sd2147483648; hi_v = 64'sd2147483647; nb_word = 32'd256; end
        1: begin lo_v = -64'sd65536; hi_v = 64'sd196608; nb_word = 32'd3; end
        2: begin lo_v = 0; hi_v = 64'sd65536; nb_word = 32'hFFFF_FE00; end
        3: begin
          lo_v = longint'($urandom_range(32'h7FFF_FFFF)) - 64'sd1073741824;
          hi_v = lo_v + 100;
          nb_word = 32'd17;
        end
        4: begin lo_v = 64'sd1000; hi_v = -64'sd1000; nb_word = 32'd40; end
        5: begin lo_v = 64'sd5; hi_v = 64'sd5; nb_word = 32'd511; end
        6: begin lo_v = -64'sd2147483648; hi_v = -64'sd2147483647; nb_word = 32'd200; end
        default: begin
          lo_v = $signed($urandom);
          hi_v = $signed($urandom);
          if (lo_v > hi_v) begin tmp = lo_v; lo_v = hi_v; hi_v = tmp; end
          if (lo_v == hi_v) hi_v = lo_v + 1;
          nb_word = $urandom_range(256, 3);
        end
      endcase
      write_reg(REG_RANGE_LOW, lo_v[31:0]);
      write_reg(REG_RANGE_HIGH, hi_v[31:0]);
      write_reg(REG_NUM_BINS, nb_word);
      @(negedge clk);
      nb = active_bins();

      // Reads at and beyond the top of the active bins.
      queue_op(OP_READ, $urandom, SEL_W'(nb - 1));
      if (nb < MAX_BINS) queue_op(OP_READ, $urandom, SEL_W'(nb));
      queue_op(OP_READ, $urandom, 8'hFF);

      calm = (p == 1);
      if (p == NUM_PHASES - 1) begin
        // Sender stops halfway and lets every result come back.
        for (int i = 0; i < PHASE_ITEMS / 2; i++) pending_ops.push_back(draw_op());
        wait_drained();
        for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++) pending_ops.push_back(draw_op());
      end else begin
        for (int i = 0; i < PHASE_ITEMS; i++) pending_ops.push_back(draw_op());
      end

      // Long receiver hold while the sender keeps offering beats.
      if (p == 0) begin
        repeat (5) @(negedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
      end
      wait_drained();
      calm = 1'b0;
    end

    if (errors == 0 && expected_bins.size() == 0) begin
      $display("range_histogram_accumulator verification clean");
    end else begin
      $display("range_histogram_accumulator verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8_000_000;
    $display("range_histogram_accumulator verification failed");
    $finish;
  end

endmodule
